/* src/vna_pkg.sv */
package vna_pkg;

   localparam int VERTEX_COUNT_DEF = 4096;
   localparam int VID_W = 12;
   localparam int FACE_W = 16;
   localparam int SUM_W = 24;
   localparam int UNIT_W = 16;
   localparam int ENTRY_W = 3 * SUM_W;

   // action codes carried in req_tuser
   localparam logic [1:0] ACT_ACCUM = 2'd0;
   localparam logic [1:0] ACT_READ = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [UNIT_W-1:0] unit_type;

   // normalizer result group
   typedef struct packed {
      logic done;
      logic zero;
      unit_type ux;
      unit_type uy;
      unit_type uz;
   } norm_out_type;

endpackage

/* src/vertex_normal_accumulator_core.sv */
// channel | ports   | tdata (low bit up)                        | tuser
// request | req_*   | vertex_a, vertex_b, vertex_c, fx, fy, fz  | action
// result  | rsp_*   | vertex_id, unit_x, unit_y, unit_z         | zero_length
//
// accumulate: a read then a write for each in-range one of three vertices, through
// the memory's read and write ports. read: the shared subtract unit does 31 root
// steps and 3 x 16 quotient steps. clear: every entry is written with zero.
// after reset a clearing pass over all VERTEX_COUNT entries runs with req_tready low.
// a finished read result waits in the output register while the next item
// is taken; a new result waits until that register is free.
module vertex_normal_accumulator_core #(
   parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // vertex_a, vertex_b, vertex_c, face_x, face_y, face_z, zero fill
   input  logic [87:0] req_tdata,
   // action
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // vertex_id, unit_x, unit_y, unit_z
   output logic [63:0] rsp_tdata,
   // zero_length
   output logic [0:0] rsp_tuser
);
   import vna_pkg::*;

   localparam int ADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VERTEX_COUNT - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_CLEAR, S_ACC_RD, S_ACC_WR, S_RD_RD, S_RD_WAIT, S_RD_NORM, S_RD_OUT
   } state_type;

   state_type state_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [1:0] sel_ff;
   logic [VID_W-1:0] vtx_ff [3];
   logic signed [FACE_W-1:0] face_ff [3];
   logic res_zero_ff;
   unit_type res_u_ff [3];
   logic rsp_valid_ff;
   logic [63:0] rsp_data_ff;
   logic rsp_zero_ff;

   logic [VID_W-1:0] cur_vtx;
   logic in_range;
   logic [ADDR_W-1:0] cur_addr;
   logic mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [ENTRY_W-1:0] mem_rdata;
   logic [ENTRY_W-1:0] acc_entry;
   logic norm_start;
   norm_out_type norm_res;
   logic out_free;

   function automatic sum_type sat_add(sum_type a, logic signed [FACE_W-1:0] b);
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + (SUM_W+1)'(b);
      if (s > (SUM_W+1)'(signed'({1'b0, {(SUM_W-1){1'b1}}}))) begin
         return {1'b0, {(SUM_W-1){1'b1}}};
      end else if (s < (SUM_W+1)'(signed'({2'b11, {(SUM_W-1){1'b0}}}))) begin
         return {1'b1, {(SUM_W-1){1'b0}}};
      end
      return s[SUM_W-1:0];
   endfunction

   // vertex in work and its range check
   assign cur_vtx = vtx_ff[sel_ff];
   assign in_range = (32'(cur_vtx) < 32'(VERTEX_COUNT));
   assign cur_addr = ADDR_W'(cur_vtx);

   // saturating update of the fetched entry
   always_comb begin
      acc_entry[SUM_W-1:0] = sat_add(mem_rdata[SUM_W-1:0], face_ff[0]);
      acc_entry[2*SUM_W-1:SUM_W] = sat_add(mem_rdata[2*SUM_W-1:SUM_W], face_ff[1]);
      acc_entry[3*SUM_W-1:2*SUM_W] = sat_add(mem_rdata[3*SUM_W-1:2*SUM_W], face_ff[2]);
   end

   // memory write select
   always_comb begin
      mem_we = (state_ff == S_CLEAR) || (state_ff == S_ACC_WR);
      mem_waddr = (state_ff == S_CLEAR) ? clr_cnt_ff : cur_addr;
      mem_wdata = (state_ff == S_CLEAR) ? '0 : acc_entry;
   end

   vna_mem #(
      .DEPTH(VERTEX_COUNT),
      .ADDR_W(ADDR_W)
   ) u_mem (
      .clock(clock),
      .we(mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(cur_addr),
      .rdata(mem_rdata)
   );

   assign norm_start = (state_ff == S_RD_WAIT);

   vna_norm u_norm (
      .clock(clock),
      .reset(reset),
      .start(norm_start),
      .in_x(mem_rdata[SUM_W-1:0]),
      .in_y(mem_rdata[2*SUM_W-1:SUM_W]),
      .in_z(mem_rdata[3*SUM_W-1:2*SUM_W]),
      .result(norm_res)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_RD_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  vtx_ff[0] <= req_tdata[11:0];
                  vtx_ff[1] <= req_tdata[23:12];
                  vtx_ff[2] <= req_tdata[35:24];
                  face_ff[0] <= req_tdata[51:36];
                  face_ff[1] <= req_tdata[67:52];
                  face_ff[2] <= req_tdata[83:68];
                  sel_ff <= 2'd0;
                  clr_cnt_ff <= '0;
                  case (req_tuser)
                     ACT_ACCUM: state_ff <= S_ACC_RD;
                     ACT_READ: state_ff <= S_RD_RD;
                     ACT_CLEAR: state_ff <= S_CLEAR;
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == LAST_ADDR) begin
                  state_ff <= S_IDLE;
               end
            end
            S_ACC_RD: begin
               if (in_range) begin
                  state_ff <= S_ACC_WR;
               end else if (sel_ff == 2'd2) begin
                  state_ff <= S_IDLE;
               end else begin
                  sel_ff <= sel_ff + 2'd1;
               end
            end
            S_ACC_WR: begin
               if (sel_ff == 2'd2) begin
                  state_ff <= S_IDLE;
               end else begin
                  sel_ff <= sel_ff + 2'd1;
                  state_ff <= S_ACC_RD;
               end
            end
            S_RD_RD: begin
               if (in_range) begin
                  state_ff <= S_RD_WAIT;
               end else begin
                  res_zero_ff <= 1'b1;
                  res_u_ff[0] <= '0;
                  res_u_ff[1] <= '0;
                  res_u_ff[2] <= '0;
                  state_ff <= S_RD_OUT;
               end
            end
            S_RD_WAIT: begin
               state_ff <= S_RD_NORM;
            end
            S_RD_NORM: begin
               if (norm_res.done) begin
                  res_zero_ff <= norm_res.zero;
                  res_u_ff[0] <= norm_res.ux;
                  res_u_ff[1] <= norm_res.uy;
                  res_u_ff[2] <= norm_res.uz;
                  state_ff <= S_RD_OUT;
               end
            end
            S_RD_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= {4'b0, res_u_ff[2], res_u_ff[1], res_u_ff[0], vtx_ff[0]};
                  rsp_zero_ff <= res_zero_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_zero_ff;

`ifndef SYNTH
   // a zero-length result carries zero components
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[59:12] == '0)
      else $error("zero_length result with nonzero components");

   // memory is written only by the clearing pass or an accumulate update
   a_we_phase: assert property (@(posedge clock)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_ACC_WR))
      else $error("memory write outside clear or accumulate");

   // normalizer finishes only while a read waits for it
   a_norm_done: assert property (@(posedge clock) disable iff (reset)
      norm_res.done |-> state_ff == S_RD_NORM)
      else $error("normalizer done outside read");
`endif

endmodule

/* src/vna_mem.sv */
module vna_mem #(
   parameter int DEPTH = vna_pkg::VERTEX_COUNT_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic clock,
   input  logic we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [vna_pkg::ENTRY_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [vna_pkg::ENTRY_W-1:0] rdata
);
   import vna_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* src/vna_norm.sv */
module vna_norm (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  vna_pkg::sum_type in_x,
   input  vna_pkg::sum_type in_y,
   input  vna_pkg::sum_type in_z,
   output vna_pkg::norm_out_type result
);
   import vna_pkg::*;

   typedef enum logic [2:0] {
      N_IDLE, N_SQ, N_ZC, N_SQRT, N_DSET, N_DIV, N_DSTORE
   } nstate_type;

   nstate_type st_ff;
   logic [4:0] cnt_ff;
   logic [1:0] k_ff;
   sum_type comp_ff [3];
   unit_type u_ff [3];
   logic [46:0] prod_ff;
   logic [47:0] sum_ff;
   logic [61:0] v_ff;
   logic [32:0] rem_ff;
   logic [30:0] root_ff;
   logic [15:0] nlo_ff;
   logic [15:0] q_ff;
   logic done_ff;
   logic zero_ff;

   logic [33:0] op_a;
   logic [33:0] op_b;
   logic [34:0] diff;
   logic ge;
   sum_type cur;
   logic [23:0] mag;
   logic [45:0] num;

   // shared subtract and compare unit
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (st_ff)
         N_SQRT: begin
            op_a = {rem_ff[31:0], v_ff[61:60]};
            op_b = {1'b0, root_ff, 2'b01};
         end
         N_DIV: begin
            op_a = {1'b0, rem_ff[31:0], nlo_ff[15]};
            op_b = {2'b00, root_ff, 1'b0};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      diff = {1'b0, op_a} - {1'b0, op_b};
      ge = !diff[34];
   end

   // magnitude and dividend for the component in work
   always_comb begin
      cur = comp_ff[k_ff];
      mag = cur[SUM_W-1] ? 24'(-cur) : 24'(cur);
      num = {mag, 22'b0} + {15'b0, root_ff};
   end

   // sequencer: squares, zero check, square root, three divisions
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= N_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (st_ff)
            N_IDLE: begin
               if (start) begin
                  comp_ff[0] <= in_x;
                  comp_ff[1] <= in_y;
                  comp_ff[2] <= in_z;
                  cnt_ff <= '0;
                  sum_ff <= '0;
                  st_ff <= N_SQ;
               end
            end
            N_SQ: begin
               if (cnt_ff < 5'd3) begin
                  prod_ff <= 47'(comp_ff[cnt_ff[1:0]] * comp_ff[cnt_ff[1:0]]);
               end
               if (cnt_ff != 5'd0) begin
                  sum_ff <= sum_ff + {1'b0, prod_ff};
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd3) begin
                  st_ff <= N_ZC;
               end
            end
            N_ZC: begin
               if (sum_ff == '0) begin
                  zero_ff <= 1'b1;
                  u_ff[0] <= '0;
                  u_ff[1] <= '0;
                  u_ff[2] <= '0;
                  done_ff <= 1'b1;
                  st_ff <= N_IDLE;
               end else begin
                  v_ff <= {sum_ff, 14'b0};
                  rem_ff <= '0;
                  root_ff <= '0;
                  cnt_ff <= '0;
                  st_ff <= N_SQRT;
               end
            end
            N_SQRT: begin
               if (ge) begin
                  rem_ff <= diff[32:0];
                  root_ff <= {root_ff[29:0], 1'b1};
               end else begin
                  rem_ff <= op_a[32:0];
                  root_ff <= {root_ff[29:0], 1'b0};
               end
               v_ff <= {v_ff[59:0], 2'b00};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd30) begin
                  k_ff <= 2'd0;
                  st_ff <= N_DSET;
               end
            end
            N_DSET: begin
               rem_ff <= {3'b000, num[45:16]};
               nlo_ff <= num[15:0];
               q_ff <= '0;
               cnt_ff <= '0;
               st_ff <= N_DIV;
            end
            N_DIV: begin
               if (ge) begin
                  rem_ff <= diff[32:0];
                  q_ff <= {q_ff[14:0], 1'b1};
               end else begin
                  rem_ff <= op_a[32:0];
                  q_ff <= {q_ff[14:0], 1'b0};
               end
               nlo_ff <= {nlo_ff[14:0], 1'b0};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd15) begin
                  st_ff <= N_DSTORE;
               end
            end
            N_DSTORE: begin
               u_ff[k_ff] <= cur[SUM_W-1] ? unit_type'(-q_ff) : unit_type'(q_ff);
               if (k_ff == 2'd2) begin
                  zero_ff <= 1'b0;
                  done_ff <= 1'b1;
                  st_ff <= N_IDLE;
               end else begin
                  k_ff <= k_ff + 2'd1;
                  st_ff <= N_DSET;
               end
            end
            default: begin
               st_ff <= N_IDLE;
            end
         endcase
      end
   end

   assign result.done = done_ff;
   assign result.zero = zero_ff;
   assign result.ux = u_ff[0];
   assign result.uy = u_ff[1];
   assign result.uz = u_ff[2];

endmodule
